// File: hdl/olsc_pkg.sv
// shared types, constants, microcode program and drive table for the six-step commutator
package olsc_pkg;

    localparam int PC_W       = 4;
    localparam int DIV_W      = 23;
    localparam int DIV_CNT_W  = 5;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [15:0] FAULT_WAIT_TICKS = 16'd200;
    localparam logic [15:0] MAX_STEP_TICKS   = 16'd500;
    localparam logic [15:0] MIN_RPM          = 16'd60;
    localparam logic [15:0] RPM_FALLBACK     = 16'd300;
    localparam logic [5:0]  PP_FALLBACK      = 6'd7;
    localparam logic [DIV_W-1:0] STEP_DIVIDEND = DIV_W'(10000);

    // floor(x / 100) as (x * CMP_RECIP) >> CMP_SHIFT, exact for x below 2^23
    localparam int          CMP_SHIFT = 30;
    localparam logic [23:0] CMP_RECIP = 24'd10737419;

    localparam logic [15:0] RPM_RESET    = 16'd300;
    localparam logic [5:0]  PP_RESET     = 6'd7;
    localparam logic [6:0]  DUTY_RESET   = 7'd25;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [15:0] ALIGN_RESET  = 16'd100;

    localparam logic [1:0] DRV_FLOAT = 2'd0;
    localparam logic [1:0] DRV_PWM   = 2'd1;
    localparam logic [1:0] DRV_LOW   = 2'd2;

    typedef enum logic [2:0] {
        MODE_ALIGN = 3'b001,
        MODE_RUN   = 3'b010,
        MODE_FAULT = 3'b100
    } mode_t;

    typedef enum logic [2:0] {
        REG_RPM    = 3'd0,
        REG_PP     = 3'd1,
        REG_DUTY   = 3'd2,
        REG_PERIOD = 3'd3,
        REG_ALIGN  = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_START_CMP,
        OP_SCALE_CMP,
        OP_LATCH_CMP,
        OP_START_SP,
        OP_STEP,
        OP_FAULT,
        OP_DEC,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_DIV_BUSY,
        COND_COUNTING,
        COND_FAULT,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        logic no_item;
        logic div_busy;
        logic counting;
        logic fault;
        logic out_busy;
    } flags_t;

    localparam logic [PC_W-1:0] UA_TAKE      = 4'd0;
    localparam logic [PC_W-1:0] UA_CMP       = 4'd1;
    localparam logic [PC_W-1:0] UA_CMP_SCALE = 4'd2;
    localparam logic [PC_W-1:0] UA_CMP_LAT   = 4'd3;
    localparam logic [PC_W-1:0] UA_CHECK     = 4'd4;
    localparam logic [PC_W-1:0] UA_SP        = 4'd5;
    localparam logic [PC_W-1:0] UA_SP_WAIT   = 4'd6;
    localparam logic [PC_W-1:0] UA_STEP      = 4'd7;
    localparam logic [PC_W-1:0] UA_FAULT     = 4'd8;
    localparam logic [PC_W-1:0] UA_DEC       = 4'd9;
    localparam logic [PC_W-1:0] UA_EMIT      = 4'd10;
    localparam logic [PC_W-1:0] UA_LOOP      = 4'd11;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: UA_TAKE};
        unique case (pc)
            UA_TAKE:      w = '{op: OP_TAKE,      cond: COND_NO_ITEM,  target: UA_TAKE};
            UA_CMP:       w = '{op: OP_START_CMP, cond: COND_NEVER,    target: UA_TAKE};
            UA_CMP_SCALE: w = '{op: OP_SCALE_CMP, cond: COND_NEVER,    target: UA_TAKE};
            UA_CMP_LAT:   w = '{op: OP_LATCH_CMP, cond: COND_COUNTING, target: UA_DEC};
            UA_CHECK:     w = '{op: OP_NOP,       cond: COND_FAULT,    target: UA_FAULT};
            UA_SP:        w = '{op: OP_START_SP,  cond: COND_NEVER,    target: UA_TAKE};
            UA_SP_WAIT:   w = '{op: OP_NOP,       cond: COND_DIV_BUSY, target: UA_SP_WAIT};
            UA_STEP:      w = '{op: OP_STEP,      cond: COND_ALWAYS,   target: UA_EMIT};
            UA_FAULT:     w = '{op: OP_FAULT,     cond: COND_ALWAYS,   target: UA_EMIT};
            UA_DEC:       w = '{op: OP_DEC,       cond: COND_NEVER,    target: UA_TAKE};
            UA_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_BUSY, target: UA_EMIT};
            UA_LOOP:      w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: UA_TAKE};
            default:      w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: UA_TAKE};
        endcase
        return w;
    endfunction

    // phase a, b, c drive codes for steps 1..6
    function automatic logic [5:0] drive_row(input logic [2:0] step);
        logic [5:0] r;
        r = {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
        unique case (step)
            3'd1:    r = {DRV_PWM,   DRV_LOW,   DRV_FLOAT};
            3'd2:    r = {DRV_PWM,   DRV_FLOAT, DRV_LOW};
            3'd3:    r = {DRV_FLOAT, DRV_PWM,   DRV_LOW};
            3'd4:    r = {DRV_LOW,   DRV_PWM,   DRV_FLOAT};
            3'd5:    r = {DRV_LOW,   DRV_FLOAT, DRV_PWM};
            3'd6:    r = {DRV_FLOAT, DRV_LOW,   DRV_PWM};
            default: r = {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
        endcase
        return r;
    endfunction

endpackage

// File: hdl/olsc_div.sv
// iterative restoring divider, one quotient bit per cycle
module olsc_div
    import olsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dq_reg, dq_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
            dq_next   = {dq_reg[DIV_W-2:0], ~diff[DIV_W]};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

// File: hdl/olsc_seq.sv
// microcode sequencer: step counter, program table and conditional jumps
module olsc_seq
    import olsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ucode_t ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            jump;

    always_comb
    begin
        ctrl = ucode_rom(pc_reg);
        unique case (ctrl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_ITEM:  jump = flags.no_item;
            COND_DIV_BUSY: jump = flags.div_busy;
            COND_COUNTING: jump = flags.counting;
            COND_FAULT:    jump = flags.fault;
            COND_OUT_BUSY: jump = flags.out_busy;
            default:       jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= UA_TAKE;
        else
            pc_reg <= pc_next;
    end

endmodule

// File: hdl/open_loop_six_step_commutator_unit.sv
// top level: register port, commutation datapath, sequencer and divider
// Open-loop six-step commutator. Each input word is one millisecond tick carrying the gate
// driver fault flag, and each tick yields exactly one output word with the three phase drive
// codes, the PWM compare, the applied step and a fault reset request. One word is in work at
// a time: each tick runs the compare steps, then decrements a running countdown, reloads the
// fault wait on a fault at expiry, or otherwise waits for the restoring divider that computes
// the step period. The PWM compare is a reciprocal multiplication spread over three program
// steps. A new word is taken while the previous result still waits in the output register.
// Registers sit at byte addresses 0, 4, 8, 12 and 16 (rpm, pole pairs, duty, PWM period,
// align time) and must be written only while idle; the block itself does not enforce this.
module open_loop_six_step_commutator_unit
    import olsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               fault_present,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         phase_a_drive,
    output logic [1:0]         phase_b_drive,
    output logic [1:0]         phase_c_drive,
    output logic [15:0]        pwm_compare,
    output logic [2:0]         active_step,
    output logic               fault_reset_request
);

    logic [15:0] rpm_reg;
    logic [5:0]  pp_reg;
    logic [6:0]  duty_reg;
    logic [15:0] period_reg;
    logic [15:0] align_reg;

    mode_t       mode_reg;
    logic [15:0] countdown_reg;
    logic [2:0]  next_step_reg;
    logic [2:0]  applied_step_reg;
    logic        fault_reg;
    logic        req_reg;
    logic [22:0] cmp_prod_reg;
    logic [16:0] cmp_q_reg;
    logic [15:0] cmp_reg;

    logic        out_valid_reg;
    logic [1:0]  pa_reg, pb_reg, pc_reg;
    logic [15:0] out_cmp_reg;
    logic [2:0]  out_step_reg;
    logic        out_req_reg;

    logic             wr_en;
    reg_idx_t         reg_idx;
    ucode_t           ctrl;
    flags_t           flags;
    logic             div_start;
    logic             div_busy;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_q;
    logic [15:0]      rpm_eff;
    logic [5:0]       pp_eff;
    logic [21:0]      sp_prod;
    logic [46:0]      cmp_recip_prod;
    logic [16:0]      cmp_low;
    logic [15:0]      cmp_clamped;
    logic [15:0]      sp_clamped;
    logic             out_free;
    logic             emit;
    logic [5:0]       row;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        unique case (reg_idx)
            REG_RPM:    prdata = PDATA_W'(rpm_reg);
            REG_PP:     prdata = PDATA_W'(pp_reg);
            REG_DUTY:   prdata = PDATA_W'(duty_reg);
            REG_PERIOD: prdata = PDATA_W'(period_reg);
            REG_ALIGN:  prdata = PDATA_W'(align_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_reg    <= RPM_RESET;
            pp_reg     <= PP_RESET;
            duty_reg   <= DUTY_RESET;
            period_reg <= PERIOD_RESET;
            align_reg  <= ALIGN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RPM:    rpm_reg    <= pwdata[15:0];
                REG_PP:     pp_reg     <= pwdata[5:0];
                REG_DUTY:   duty_reg   <= pwdata[6:0];
                REG_PERIOD: period_reg <= pwdata[15:0];
                REG_ALIGN:  align_reg  <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    // sequencer and its condition flags
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        flags.no_item  = !in_valid;
        flags.div_busy = div_busy;
        flags.counting = (countdown_reg > 16'd1);
        flags.fault    = fault_reg;
        flags.out_busy = !out_free;
    end

    olsc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign in_stall = (ctrl.op != OP_TAKE);
    assign emit     = (ctrl.op == OP_EMIT) && out_free;

    // divider operands, step period only
    assign rpm_eff      = (rpm_reg < MIN_RPM) ? RPM_FALLBACK : rpm_reg;
    assign pp_eff       = (pp_reg == 6'd0) ? PP_FALLBACK : pp_reg;
    assign sp_prod      = 22'(rpm_eff) * 22'(pp_eff);
    assign div_start    = (ctrl.op == OP_START_SP);
    assign div_dividend = STEP_DIVIDEND;
    assign div_divisor  = DIV_W'(sp_prod);

    olsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // compare: product, scale by the reciprocal of 100, then clamp
    assign cmp_recip_prod = 47'(cmp_prod_reg) * 47'(CMP_RECIP);
    assign cmp_low        = (cmp_q_reg == '0) ? 17'd1 : cmp_q_reg;
    assign cmp_clamped    = (cmp_low > 17'(period_reg)) ? period_reg : cmp_low[15:0];
    assign sp_clamped     = (div_q > DIV_W'(MAX_STEP_TICKS)) ? MAX_STEP_TICKS :
                            (div_q == '0) ? 16'd1 : div_q[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_ALIGN;
            countdown_reg    <= ALIGN_RESET;
            next_step_reg    <= 3'd1;
            applied_step_reg <= 3'd1;
            fault_reg        <= 1'b0;
            req_reg          <= 1'b0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_TAKE:
                begin
                    fault_reg <= fault_present;
                    req_reg   <= 1'b0;
                end
                OP_STEP:
                begin
                    applied_step_reg <= next_step_reg;
                    mode_reg         <= MODE_RUN;
                    next_step_reg    <= (next_step_reg >= 3'd6) ? 3'd1 : next_step_reg + 3'd1;
                    countdown_reg    <= sp_clamped;
                end
                OP_FAULT:
                begin
                    mode_reg      <= MODE_FAULT;
                    req_reg       <= 1'b1;
                    countdown_reg <= FAULT_WAIT_TICKS;
                end
                OP_DEC:
                    countdown_reg <= countdown_reg - 16'd1;
                default: ;
            endcase
            // align time rewrite restarts the align countdown
            if (wr_en && (reg_idx == REG_ALIGN) && (mode_reg == MODE_ALIGN))
                countdown_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_START_CMP)
            cmp_prod_reg <= 23'(period_reg) * 23'(duty_reg);
        if (ctrl.op == OP_SCALE_CMP)
            cmp_q_reg <= cmp_recip_prod[CMP_SHIFT+16:CMP_SHIFT];
        if (ctrl.op == OP_LATCH_CMP)
            cmp_reg <= cmp_clamped;
    end

    // output word register
    assign row = drive_row(applied_step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (mode_reg == MODE_FAULT)
            begin
                pa_reg       <= DRV_FLOAT;
                pb_reg       <= DRV_FLOAT;
                pc_reg       <= DRV_FLOAT;
                out_cmp_reg  <= 16'd0;
                out_step_reg <= 3'd0;
            end
            else
            begin
                pa_reg       <= row[5:4];
                pb_reg       <= row[3:2];
                pc_reg       <= row[1:0];
                out_cmp_reg  <= cmp_reg;
                out_step_reg <= applied_step_reg;
            end
            out_req_reg <= req_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign phase_a_drive       = pa_reg;
    assign phase_b_drive       = pb_reg;
    assign phase_c_drive       = pc_reg;
    assign pwm_compare         = out_cmp_reg;
    assign active_step         = out_step_reg;
    assign fault_reset_request = out_req_reg;

    // a fault word always has a zero step and a zero compare
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault_reset_request) |-> (active_step == 3'd0 && pwm_compare == 16'd0))
        else $error("fault word with phases driven");

    // the divider is idle whenever a new word may be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_TAKE) |-> !div_busy)
        else $error("divider busy at word intake");

    // a step or fault reload never leaves a zero countdown
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_STEP || ctrl.op == OP_FAULT) |=> (countdown_reg != 16'd0))
        else $error("zero countdown after reload");

    // applied step stays within one to six
    assert property (@(posedge clk) disable iff (!rst_n)
        $changed(applied_step_reg) |-> (applied_step_reg >= 3'd1 && applied_step_reg <= 3'd6))
        else $error("applied step out of range");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the open-loop six-step commutator unit
module tb_top;
    import olsc_pkg::*;

    localparam int HOLD_FAULT_TICKS = 200;
    localparam int STEP_TICKS_CAP   = 500;
    localparam int SETTLE_CYCLES    = 8;
    localparam int END_CYCLES       = 60;
    localparam int WATCHDOG_LIMIT   = 5000;

    typedef enum logic [2:0] {
        ST_ALIGN = 3'b001,
        ST_RUN   = 3'b010,
        ST_FAULT = 3'b100
    } spin_state_t;

    typedef struct packed {
        logic [1:0]  a;
        logic [1:0]  b;
        logic [1:0]  c;
        logic [15:0] cmp;
        logic [2:0]  step;
        logic        req;
    } drive_word_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               fault_present;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         phase_a_drive;
    logic [1:0]         phase_b_drive;
    logic [1:0]         phase_c_drive;
    logic [15:0]        pwm_compare;
    logic [2:0]         active_step;
    logic               fault_reset_request;

    // register shadows
    logic [15:0] cfg_rpm;
    logic [5:0]  cfg_pp;
    logic [6:0]  cfg_duty;
    logic [15:0] cfg_period;
    logic [15:0] cfg_align;

    // commutation state
    spin_state_t p_state;
    logic [15:0] p_count;
    logic [2:0]  p_next;
    logic [2:0]  p_applied;

    drive_word_t pending_drive[$];
    int          mismatch_count;
    int          quiet_cycles;
    int          hold_off_len;
    bit          tx_gaps_on;
    bit          rx_gaps_on;

    open_loop_six_step_commutator_unit u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .fault_present       (fault_present),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .phase_a_drive       (phase_a_drive),
        .phase_b_drive       (phase_b_drive),
        .phase_c_drive       (phase_c_drive),
        .pwm_compare         (pwm_compare),
        .active_step         (active_step),
        .fault_reset_request (fault_reset_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [5:0] step_drive(input logic [2:0] s);
        case (s)
            3'd1:    return {DRV_PWM,   DRV_LOW,   DRV_FLOAT};
            3'd2:    return {DRV_PWM,   DRV_FLOAT, DRV_LOW};
            3'd3:    return {DRV_FLOAT, DRV_PWM,   DRV_LOW};
            3'd4:    return {DRV_LOW,   DRV_PWM,   DRV_FLOAT};
            3'd5:    return {DRV_LOW,   DRV_FLOAT, DRV_PWM};
            3'd6:    return {DRV_FLOAT, DRV_LOW,   DRV_PWM};
            default: return {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
        endcase
    endfunction

    function automatic int pwm_compare_now();
        int d;
        d = (int'(cfg_period) * int'(cfg_duty)) / 100;
        if (d < 1)
            d = 1;
        if (d > int'(cfg_period))
            d = int'(cfg_period);
        if (d > 65535)
            d = 65535;
        return d;
    endfunction

    function automatic int step_ticks_now();
        int rpm;
        int pp;
        int t;
        rpm = int'(cfg_rpm);
        pp  = int'(cfg_pp);
        if (rpm < 60)
            rpm = 300;
        if (pp < 1)
            pp = 7;
        t = 10000 / (rpm * pp);
        if (t > STEP_TICKS_CAP)
            t = STEP_TICKS_CAP;
        if (t < 1)
            t = 1;
        return t;
    endfunction

    // advance one millisecond tick and return the drive word it yields
    function automatic drive_word_t commutate_tick(input logic fault_flag);
        drive_word_t w;
        logic        req;
        req = 1'b0;
        if (p_count > 16'd1)
            p_count = p_count - 16'd1;
        else if (fault_flag)
        begin
            p_state = ST_FAULT;
            req     = 1'b1;
            p_count = 16'(HOLD_FAULT_TICKS);
        end
        else
        begin
            p_applied = p_next;
            p_state   = ST_RUN;
            p_next    = (p_next >= 3'd6) ? 3'd1 : p_next + 3'd1;
            p_count   = 16'(step_ticks_now());
        end
        w = '0;
        if (p_state != ST_FAULT && p_applied >= 3'd1 && p_applied <= 3'd6)
        begin
            {w.a, w.b, w.c} = step_drive(p_applied);
            w.cmp  = 16'(pwm_compare_now());
            w.step = p_applied;
        end
        w.req = req;
        return w;
    endfunction

    function automatic logic [31:0] reg_shadow(input logic [2:0] idx);
        case (idx)
            REG_RPM:    return 32'(cfg_rpm);
            REG_PP:     return 32'(cfg_pp);
            REG_DUTY:   return 32'(cfg_duty);
            REG_PERIOD: return 32'(cfg_period);
            REG_ALIGN:  return 32'(cfg_align);
            default:    return 32'd0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data,
                              output logic [31:0] rd);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== reg_shadow(idx))
            report_mismatch($sformatf("register %0d readback", idx), rd, reg_shadow(idx));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_RPM:    cfg_rpm    = value[15:0];
            REG_PP:     cfg_pp     = value[5:0];
            REG_DUTY:   cfg_duty   = value[6:0];
            REG_PERIOD: cfg_period = value[15:0];
            REG_ALIGN:
            begin
                cfg_align = value[15:0];
                if (p_state == ST_ALIGN)
                    p_count = value[15:0];
            end
            default: ;
        endcase
        if (idx <= REG_ALIGN)
            check_reg(idx);
    endtask

    task automatic send_tick(input logic fault_flag);
        int unsigned gap;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid      = 1'b0;
            fault_present = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        fault_present = fault_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_drive.push_back(commutate_tick(fault_flag));
    endtask

    task automatic drain_ticks();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // faults ignored while aligning, align time rewritten mid-align, zero align
    task automatic test_align_rewrite();
        send_tick(1'b1);
        send_tick(1'b0);
        drain_ticks();
        write_reg(REG_ALIGN, 32'd65535);
        send_tick(1'b1);
        drain_ticks();
        write_reg(REG_ALIGN, 32'd0);
        send_tick(1'b0);
        drain_ticks();
        write_reg(REG_ALIGN, 32'd1);
        send_tick(1'b0);
    endtask

    // full step wrap at period one, compare extremes, rpm and pole pair fallbacks
    task automatic test_drive_corners();
        drain_ticks();
        write_reg(REG_RPM, 32'd65535);
        write_reg(REG_PP, 32'hFFFF_FFFF);
        repeat (9) send_tick(1'b0);
        drain_ticks();
        write_reg(REG_DUTY, 32'hFFFF_FFFF);
        send_tick(1'b0);
        drain_ticks();
        write_reg(REG_PERIOD, 32'd0);
        send_tick(1'b0);
        drain_ticks();
        write_reg(REG_PERIOD, 32'hFFFF_FFFF);
        send_tick(1'b0);
        drain_ticks();
        write_reg(REG_DUTY, 32'd0);
        send_tick(1'b0);
        drain_ticks();
        write_reg(REG_DUTY, 32'd100);
        write_reg(REG_RPM, 32'd59);
        write_reg(REG_PP, 32'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_ticks();
        write_reg(REG_RPM, 32'd60);
        write_reg(REG_PP, 32'd1);
        repeat (4) send_tick(1'b0);
    endtask

    // spare addresses must not disturb any register
    task automatic test_register_map();
        drain_ticks();
        for (int i = int'(REG_ALIGN) + 1; i < 8; i++)
            write_reg(3'(i), $urandom);
        for (int i = int'(REG_RPM); i <= int'(REG_ALIGN); i++)
            check_reg(3'(i));
        repeat (4) send_tick(1'b0);
    endtask

    // fault at expiry, ignored flags during the wait, then the pending step
    task automatic test_fault_recovery();
        while (p_count > 16'd1)
            send_tick(1'($urandom_range(0, 1)));
        send_tick(1'b1);
        repeat (HOLD_FAULT_TICKS) send_tick(1'($urandom_range(0, 1)));
        repeat (20) send_tick(1'b0);
    endtask

    // receiver holds off long enough for the unit to stall its input
    task automatic test_backpressure();
        drain_ticks();
        write_reg(REG_RPM, 32'($urandom_range(2000, 65535)));
        write_reg(REG_PP, 32'($urandom_range(1, 63)));
        hold_off_len = 400;
        repeat (30) send_tick(1'($urandom_range(0, 19) == 0));
        drain_ticks();
    endtask

    task automatic run_random_phase(input int n_ticks);
        int unsigned fault_pct;
        int unsigned v;
        drain_ticks();
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 59);
            1:       v = 60;
            2:       v = 65535;
            3, 4:    v = $urandom_range(60, 400);
            default: v = $urandom_range(0, 65535);
        endcase
        write_reg(REG_RPM, (32'($urandom) << 16) | v);
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 63;
            2:       v = $urandom_range(1, 4);
            default: v = $urandom_range(0, 63);
        endcase
        write_reg(REG_PP, (32'($urandom) << 6) | v);
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 100;
            2:       v = 127;
            default: v = $urandom_range(0, 127);
        endcase
        write_reg(REG_DUTY, (32'($urandom) << 7) | v);
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 1;
            2:       v = 65535;
            default: v = $urandom_range(0, 65535);
        endcase
        write_reg(REG_PERIOD, (32'($urandom) << 16) | v);
        write_reg(REG_ALIGN, $urandom);
        fault_pct = $urandom_range(0, 5);
        repeat (n_ticks) send_tick(1'($urandom_range(0, 99) < fault_pct));
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 6; i++)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            run_random_phase(90);
        end
    endtask

    task automatic test_full_rate();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random_phase(80);
    endtask

    // receiver side stall
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_len > 0)
            begin
                out_stall = 1'b1;
                repeat (hold_off_len) @(negedge clk);
                hold_off_len = 0;
                out_stall    = 1'b0;
            end
            else if (rx_gaps_on && $urandom_range(0, 3) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_output
        drive_word_t got;
        drive_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {phase_a_drive, phase_b_drive, phase_c_drive, pwm_compare, active_step,
                   fault_reset_request};
            if (pending_drive.size() == 0)
                report_mismatch("word with nothing pending, step", got.step, 0);
            else
            begin
                want = pending_drive.pop_front();
                if (got.a !== want.a)
                    report_mismatch("phase_a_drive", got.a, want.a);
                if (got.b !== want.b)
                    report_mismatch("phase_b_drive", got.b, want.b);
                if (got.c !== want.c)
                    report_mismatch("phase_c_drive", got.c, want.c);
                if (got.cmp !== want.cmp)
                    report_mismatch("pwm_compare", got.cmp, want.cmp);
                if (got.step !== want.step)
                    report_mismatch("active_step", got.step, want.step);
                if (got.req !== want.req)
                    report_mismatch("fault_reset_request", got.req, want.req);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        fault_present  = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        hold_off_len   = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        cfg_rpm        = 16'd300;
        cfg_pp         = 6'd7;
        cfg_duty       = 7'd25;
        cfg_period     = 16'd1000;
        cfg_align      = 16'd100;
        p_state        = ST_ALIGN;
        p_count        = 16'd100;
        p_next         = 3'd1;
        p_applied      = 3'd1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_align_rewrite();
        test_drive_corners();
        test_register_map();
        test_fault_recovery();
        test_backpressure();
        test_random_traffic();
        test_full_rate();

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
